### src/texture_store_nearest_sampler_unit_assert.svh
// Assertion macros for the nearest texture sampler.
// Included by the top level; no other dependencies.
`ifndef TEXTURE_STORE_NEAREST_SAMPLER_UNIT_ASSERT_SVH
`define TEXTURE_STORE_NEAREST_SAMPLER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define TSNS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define TSNS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define TSNS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TSNS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/tsns_pkg.sv
// Shared types and constants for the nearest texture sampler.
// No dependencies.
package tsns_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_FRAC_BITS  = 16;

  localparam int DIM_W      = 9;
  localparam int CH_W       = 3;
  localparam int BYTE_W     = 8;
  localparam int COORD_W    = 24;
  localparam int TEXEL_W    = 4 * BYTE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEX_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS   = 2'd2;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch input item
    logic coord;     // compute column / row
    logic addr;      // compute linear address
    logic mem;       // memory write (load) or read (sample)
    logic load_out;  // move read data into output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sample;
    logic at_origin;  // load position is row 0, column 0
  } dp_status_t;

endpackage

### src/tsns_in_if.sv
// Input item channel: load or sample command with its payload.
// Depends on tsns_pkg.
interface tsns_in_if import tsns_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic [BYTE_W-1:0]         first_byte;
  logic [BYTE_W-1:0]         second_byte;
  logic [BYTE_W-1:0]         third_byte;
  logic [BYTE_W-1:0]         fourth_byte;
  logic signed [COORD_W-1:0] u_coord;
  logic signed [COORD_W-1:0] v_coord;

  modport source (output valid, command, first_byte, second_byte, third_byte,
                  fourth_byte, u_coord, v_coord, input ready);
  modport sink (input valid, command, first_byte, second_byte, third_byte,
                fourth_byte, u_coord, v_coord, output ready);
endinterface

### src/tsns_out_if.sv
// Result item channel: one sampled RGBA texel.
// Depends on tsns_pkg.
interface tsns_out_if import tsns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] red;
  logic [BYTE_W-1:0] green;
  logic [BYTE_W-1:0] blue;
  logic [BYTE_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

### src/tsns_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on tsns_pkg.
interface tsns_cfg_if import tsns_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/texture_store_nearest_sampler_unit.sv
// Top level of the nearest-neighbor texture sampler with repeat wrap.
// Depends on tsns_pkg, the three channel interfaces, tsns_ctrl, tsns_datapath.
//
//  channel  dir  contents                                         handshake
//  in_ch    in   command, four pixel bytes, u_coord, v_coord       valid/ready
//  out_ch   out  red, green, blue, alpha                           valid/ready
//  cfg      in   index (0 width, 1 height, 2 channels), data       valid/ready
//
// Load item: accept, column/row, address, memory write, then in_ch.ready
// returns; no result.
// Sample item: accept, column/row, address, memory read, result, plus any output stall;
// the single texel memory port and the two multiplies (coordinate, then row*width) set these steps.
// A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous) clears control, config (1x1, 4 channels) and the
// load position; texel memory is not cleared. cfg is always ready.
`include "texture_store_nearest_sampler_unit_assert.svh"

module texture_store_nearest_sampler_unit import tsns_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input logic       clk,
  input logic       rst,
  tsns_in_if.sink   in_ch,
  tsns_out_if.source out_ch,
  tsns_cfg_if.sink  cfg
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;

  // register writes need no backpressure
  assign cfg.ready = 1'b1;

  tsns_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tsns_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_valid   (cfg.valid),
    .cfg_index   (cfg.index),
    .cfg_data    (cfg.data),
    .command     (in_ch.command),
    .first_byte  (in_ch.first_byte),
    .second_byte (in_ch.second_byte),
    .third_byte  (in_ch.third_byte),
    .fourth_byte (in_ch.fourth_byte),
    .u_coord     (in_ch.u_coord),
    .v_coord     (in_ch.v_coord),
    .red         (out_ch.red),
    .green       (out_ch.green),
    .blue        (out_ch.blue),
    .alpha       (out_ch.alpha)
  );

  // one item in flight: no new item right after an accept
  `TSNS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  // a register write restarts the load position
  `TSNS_ASSERT_NEXT(a_cfg_restarts_load, clk, rst, cfg.valid && (cfg.index == CFG_TEX_WIDTH || cfg.index == CFG_TEX_HEIGHT || cfg.index == CFG_CHANNELS), sts.at_origin)
  // output register is filled only while the input side is held off
  `TSNS_ASSERT_IMPL(a_result_while_busy, clk, rst, cmd.load_out, !in_ch.ready)

endmodule

### src/tsns_ctrl.sv
// Sequencing state machine and output handshake for the texture sampler.
// Depends on tsns_pkg.
module tsns_ctrl import tsns_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COORD,
    ST_ADDR,
    ST_MEM,
    ST_RESULT
  } state_t;

  state_t state;
  logic   slot_free;

  assign in_ready  = (state == ST_IDLE);
  assign slot_free = !out_valid || out_ready;

  always_comb begin
    cmd          = '0;
    cmd.capture  = in_ready && in_valid;
    cmd.coord    = (state == ST_COORD);
    cmd.addr     = (state == ST_ADDR);
    cmd.mem      = (state == ST_MEM);
    cmd.load_out = (state == ST_RESULT) && slot_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) state <= ST_COORD;
        end
        ST_COORD:  state <= ST_ADDR;
        ST_ADDR:   state <= ST_MEM;
        ST_MEM: begin
          state <= sts.is_sample ? ST_RESULT : ST_IDLE;
        end
        ST_RESULT: begin
          if (slot_free) state <= ST_IDLE;
        end
        default:   state <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/tsns_datapath.sv
// Texture sampler datapath: configuration, load position, address math,
// texel memory and output register. Depends on tsns_pkg.
module tsns_datapath import tsns_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  ctrl_cmd_t                 cmd,
  output dp_status_t                sts,
  input  logic                      cfg_valid,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic                      command,
  input  logic [BYTE_W-1:0]         first_byte,
  input  logic [BYTE_W-1:0]         second_byte,
  input  logic [BYTE_W-1:0]         third_byte,
  input  logic [BYTE_W-1:0]         fourth_byte,
  input  logic signed [COORD_W-1:0] u_coord,
  input  logic signed [COORD_W-1:0] v_coord,
  output logic [BYTE_W-1:0]         red,
  output logic [BYTE_W-1:0]         green,
  output logic [BYTE_W-1:0]         blue,
  output logic [BYTE_W-1:0]         alpha
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = DIM_W + FRAC_BITS;
  localparam int IW    = 2 * DIM_W + 1;

  localparam logic [CH_W-1:0] CH_GRAY = 3'd1;
  localparam logic [CH_W-1:0] CH_RGB  = 3'd3;
  localparam logic [CH_W-1:0] CH_RGBA = 3'd4;
  localparam logic [BYTE_W-1:0] FULL_BYTE = 8'hFF;

  // configuration and load position
  logic [DIM_W-1:0] tex_width, tex_height;
  logic [CH_W-1:0]  channel_count;
  logic [DIM_W-1:0] load_row, load_col;

  // item registers
  logic                 cmd_r;
  logic [TEXEL_W-1:0]   texel_r;
  logic [FRAC_BITS-1:0] fu_r, fv_r;
  logic [DIM_W-1:0]     col_r, row_r;
  logic [AW-1:0]        idx_r;
  logic [TEXEL_W-1:0]   rd_r;
  logic [TEXEL_W-1:0]   mem [DEPTH];

  logic [DIM_W-1:0]   w, h;
  logic [DIM_W-1:0]   col_e, row_e;
  logic [DIM_W:0]     col_inc, row_inc;
  logic [PW-1:0]      prod_u, prod_v;
  logic [IW-1:0]      idx_sum;
  logic [TEXEL_W-1:0] texel_in;
  logic               cfg_hit;

  // saturate dims to 1..MAX
  always_comb begin
    if (tex_width == '0) w = DIM_W'(1);
    else if (32'(tex_width) > 32'(MAX_WIDTH)) w = DIM_W'(MAX_WIDTH);
    else w = tex_width;
    if (tex_height == '0) h = DIM_W'(1);
    else if (32'(tex_height) > 32'(MAX_HEIGHT)) h = DIM_W'(MAX_HEIGHT);
    else h = tex_height;
  end

  assign col_e   = (load_col < w) ? load_col : '0;
  assign row_e   = (load_row < h) ? load_row : '0;
  assign col_inc = {1'b0, col_e} + 1'b1;
  assign row_inc = {1'b0, row_e} + 1'b1;

  assign prod_u  = PW'(w - 1'b1) * PW'(fu_r);
  assign prod_v  = PW'(h - 1'b1) * PW'(fv_r);
  assign idx_sum = IW'(row_r) * IW'(w) + IW'(col_r);

  always_comb begin
    case (channel_count)
      CH_GRAY: texel_in = {first_byte, first_byte, first_byte, FULL_BYTE};
      CH_RGB:  texel_in = {first_byte, second_byte, third_byte, FULL_BYTE};
      CH_RGBA: texel_in = {first_byte, second_byte, third_byte, fourth_byte};
      default: texel_in = {FULL_BYTE, FULL_BYTE, FULL_BYTE, FULL_BYTE};
    endcase
  end

  assign cfg_hit = cfg_valid && (cfg_index == CFG_TEX_WIDTH ||
                   cfg_index == CFG_TEX_HEIGHT || cfg_index == CFG_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width     <= DIM_W'(1);
      tex_height    <= DIM_W'(1);
      channel_count <= CH_W'(4);
      load_row      <= '0;
      load_col      <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_TEX_WIDTH:  tex_width     <= cfg_data;
          CFG_TEX_HEIGHT: tex_height    <= cfg_data;
          CFG_CHANNELS:   channel_count <= cfg_data[CH_W-1:0];
          default: ;
        endcase
      end
      // a config write restarts the image; it wins over an advance
      if (cfg_hit) begin
        load_row <= '0;
        load_col <= '0;
      end else if (cmd.mem && cmd_r == CMD_LOAD) begin
        if (col_inc >= {1'b0, w}) begin
          load_col <= '0;
          load_row <= (row_inc >= {1'b0, h}) ? '0 : row_inc[DIM_W-1:0];
        end else begin
          load_col <= col_inc[DIM_W-1:0];
          load_row <= row_e;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= command;
      texel_r <= texel_in;
      fu_r    <= u_coord[FRAC_BITS-1:0];
      fv_r    <= v_coord[FRAC_BITS-1:0];
    end
    if (cmd.coord) begin
      if (cmd_r == CMD_SAMPLE) begin
        col_r <= prod_u[FRAC_BITS +: DIM_W];
        row_r <= prod_v[FRAC_BITS +: DIM_W];
      end else begin
        col_r <= col_e;
        row_r <= h - 1'b1 - row_e;  // stored row 0 is the bottom row
      end
    end
    if (cmd.addr) idx_r <= AW'(idx_sum);
    if (cmd.mem) begin
      if (cmd_r == CMD_LOAD) mem[idx_r] <= texel_r;
      else rd_r <= mem[idx_r];
    end
    if (cmd.load_out) begin
      {red, green, blue, alpha} <= rd_r;
    end
  end

  assign sts.is_sample = (cmd_r == CMD_SAMPLE);
  assign sts.at_origin = (load_row == '0) && (load_col == '0);

endmodule
